// ----- rtl/gjksr_pkg.sv -----
package gjksr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DIR_BITS = 40;
    localparam logic [7:0] LIMIT_RESET = 8'd64;

    typedef enum logic [2:0] {
        STAT_CONT  = 3'd0,
        STAT_HIT   = 3'd1,
        STAT_SEP   = 3'd2,
        STAT_LIMIT = 3'd3,
        STAT_IDLE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_CROSS  = 2'd0,
        OP_DOT    = 2'd1,
        OP_SETDIR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        SS_AB = 3'd0,
        SS_AC = 3'd1,
        SS_AD = 3'd2,
        SS_AO = 3'd3,
        SS_IN = 3'd4
    } ssel_t;

    typedef enum logic [2:0] {
        WS_W0  = 3'd0,
        WS_W1  = 3'd1,
        WS_W2  = 3'd2,
        WS_DIR = 3'd3,
        WS_AB  = 3'd4,
        WS_AC  = 3'd5,
        WS_AD  = 3'd6,
        WS_AO  = 3'd7
    } wsel_t;

    typedef enum logic [1:0] {
        WD_W0 = 2'd0,
        WD_W1 = 2'd1,
        WD_W2 = 2'd2
    } wdst_t;

    typedef enum logic [2:0] {
        PM_NONE    = 3'd0,
        PM_START   = 3'd1,
        PM_PUSH    = 3'd2,
        PM_B_GETS_C = 3'd3,
        PM_SWAP_BC = 3'd4,
        PM_CD      = 3'd5,
        PM_DB      = 3'd6
    } perm_t;

    typedef struct packed {
        logic    go;
        op_t     op;
        ssel_t   ssel;
        wsel_t   wsel;
        wdst_t   dst;
        logic    neg;
        perm_t   perm;
        logic    load_in;
        logic    emit;
        status_t out_status;
        logic [2:0] out_count;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic pos;
        logic neg;
    } dp_stat_t;

endpackage

// ----- rtl/gjksr_dp.sv -----
module gjksr_dp #(
    parameter int COORD_BITS = gjksr_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  gjksr_pkg::dp_cmd_t                      cmd,
    output gjksr_pkg::dp_stat_t                     stat,
    input  logic signed [COORD_BITS-1:0]            pt_x,
    input  logic signed [COORD_BITS-1:0]            pt_y,
    input  logic signed [COORD_BITS-1:0]            pt_z,
    output logic [2:0]                              res_status,
    output logic signed [gjksr_pkg::DIR_BITS-1:0]   res_dir_x,
    output logic signed [gjksr_pkg::DIR_BITS-1:0]   res_dir_y,
    output logic signed [gjksr_pkg::DIR_BITS-1:0]   res_dir_z,
    output logic [2:0]                              res_count
);

    localparam int CB = COORD_BITS;
    localparam int DW = gjksr_pkg::DIR_BITS;
    localparam int SW = CB + 1;
    localparam int WW_MIN = 3 * SW + 2;
    localparam int WW = (WW_MIN > DW) ? WW_MIN : DW;
    localparam int PW = SW + WW;
    localparam int AW = PW + 2;
    localparam logic signed [WW:0] DMAX = {{(WW + 1 - DW){1'b0}}, 1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [WW:0] DMIN = ~DMAX;

    logic signed [CB-1:0] p_reg [4][3];
    logic signed [CB-1:0] in_reg [3];
    logic signed [WW-1:0] w0_reg [3];
    logic signed [WW-1:0] w1_reg [3];
    logic signed [WW-1:0] w2_reg [3];
    logic signed [DW-1:0] dir_reg [3];

    logic signed [SW-1:0] ab [3];
    logic signed [SW-1:0] ac [3];
    logic signed [SW-1:0] ad [3];
    logic signed [SW-1:0] ao [3];
    logic signed [SW-1:0] iv [3];
    logic signed [SW-1:0] svec [3];
    logic signed [WW-1:0] wvec [3];
    logic signed [DW-1:0] fixed [3];

    logic                 busy_reg;
    gjksr_pkg::op_t       op_reg;
    gjksr_pkg::ssel_t     ssel_reg;
    gjksr_pkg::wsel_t     wsel_reg;
    gjksr_pkg::wdst_t     dst_reg;
    logic                 neg_reg;
    logic [2:0]           idx_reg;

    logic                 pv_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 psub_reg;
    logic                 pfirst_reg;
    logic                 plast_reg;
    logic                 pfinal_reg;
    logic                 pcross_reg;
    logic [1:0]           pcomp_reg;
    logic signed [AW-1:0] acc_reg;

    logic                 done_reg;
    logic                 pos_reg;
    logic                 negf_reg;

    logic [1:0]           si;
    logic [1:0]           wi;
    logic                 isub;
    logic                 ifirst;
    logic                 ilast;
    logic                 ifinal;
    logic [1:0]           icomp;
    logic                 issue;
    logic signed [SW-1:0] s_op;
    logic signed [WW-1:0] w_op;
    logic signed [PW-1:0] prod_c;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] acc_c;
    logic signed [WW-1:0] comp_val;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ab[k] = SW'(p_reg[1][k]) - SW'(p_reg[0][k]);
            ac[k] = SW'(p_reg[2][k]) - SW'(p_reg[0][k]);
            ad[k] = SW'(p_reg[3][k]) - SW'(p_reg[0][k]);
            ao[k] = -SW'(p_reg[0][k]);
            iv[k] = SW'(in_reg[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            unique case (ssel_reg)
                gjksr_pkg::SS_AB: svec[k] = ab[k];
                gjksr_pkg::SS_AC: svec[k] = ac[k];
                gjksr_pkg::SS_AD: svec[k] = ad[k];
                gjksr_pkg::SS_AO: svec[k] = ao[k];
                default:          svec[k] = iv[k];
            endcase
            unique case (wsel_reg)
                gjksr_pkg::WS_W0:  wvec[k] = w0_reg[k];
                gjksr_pkg::WS_W1:  wvec[k] = w1_reg[k];
                gjksr_pkg::WS_W2:  wvec[k] = w2_reg[k];
                gjksr_pkg::WS_DIR: wvec[k] = WW'(dir_reg[k]);
                gjksr_pkg::WS_AB:  wvec[k] = WW'(ab[k]);
                gjksr_pkg::WS_AC:  wvec[k] = WW'(ac[k]);
                gjksr_pkg::WS_AD:  wvec[k] = WW'(ad[k]);
                gjksr_pkg::WS_AO:  wvec[k] = WW'(ao[k]);
            endcase
        end
    end

    // product schedule: cross takes six terms, dot three
    always_comb begin
        si = 2'd0;
        wi = 2'd0;
        isub = 1'b0;
        ifirst = 1'b1;
        ilast = 1'b0;
        ifinal = 1'b0;
        icomp = 2'd0;
        if (op_reg == gjksr_pkg::OP_CROSS) begin
            unique case (idx_reg)
                3'd0: begin si = 2'd1; wi = 2'd2; end
                3'd1: begin si = 2'd2; wi = 2'd1; isub = 1'b1; ifirst = 1'b0; ilast = 1'b1; end
                3'd2: begin si = 2'd2; wi = 2'd0; icomp = 2'd1; end
                3'd3: begin
                    si = 2'd0; wi = 2'd2; isub = 1'b1; ifirst = 1'b0; ilast = 1'b1;
                    icomp = 2'd1;
                end
                3'd4: begin si = 2'd0; wi = 2'd1; icomp = 2'd2; end
                default: begin
                    si = 2'd1; wi = 2'd0; isub = 1'b1; ifirst = 1'b0; ilast = 1'b1;
                    ifinal = 1'b1; icomp = 2'd2;
                end
            endcase
            isub = isub ^ neg_reg;
        end else begin
            si = idx_reg[1:0];
            wi = idx_reg[1:0];
            ifirst = (idx_reg == 3'd0);
            ifinal = (idx_reg == 3'd2);
        end
    end

    assign issue  = busy_reg && (op_reg != gjksr_pkg::OP_SETDIR);
    assign s_op   = svec[si];
    assign w_op   = wvec[wi];
    assign prod_c = s_op * w_op;
    assign addend = psub_reg ? -AW'(prod_reg) : AW'(prod_reg);
    assign acc_c  = (pfirst_reg ? AW'(0) : acc_reg) + addend;
    assign comp_val = acc_c[WW-1:0];

    always_comb begin
        logic signed [WW:0] v;
        for (int k = 0; k < 3; k++) begin
            v = neg_reg ? -(WW + 1)'(wvec[k]) : (WW + 1)'(wvec[k]);
            if (v > DMAX) begin
                fixed[k] = DMAX[DW-1:0];
            end else if (v < DMIN) begin
                fixed[k] = DMIN[DW-1:0];
            end else begin
                fixed[k] = v[DW-1:0];
            end
        end
        if (fixed[0] == '0 && fixed[1] == '0 && fixed[2] == '0) begin
            fixed[0] = DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            pv_reg   <= issue;
            if (cmd.go) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && op_reg == gjksr_pkg::OP_SETDIR) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else if (issue && ifinal) begin
                busy_reg <= 1'b0;
            end
            if (pv_reg && pfinal_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            op_reg   <= cmd.op;
            ssel_reg <= cmd.ssel;
            wsel_reg <= cmd.wsel;
            dst_reg  <= cmd.dst;
            neg_reg  <= cmd.neg;
            idx_reg  <= 3'd0;
        end else if (issue) begin
            idx_reg <= idx_reg + 3'd1;
        end
        if (issue) begin
            prod_reg   <= prod_c;
            psub_reg   <= isub;
            pfirst_reg <= ifirst;
            plast_reg  <= ilast;
            pfinal_reg <= ifinal;
            pcross_reg <= (op_reg == gjksr_pkg::OP_CROSS);
            pcomp_reg  <= icomp;
        end
        if (pv_reg) begin
            acc_reg <= acc_c;
            if (pcross_reg && plast_reg) begin
                unique case (dst_reg)
                    gjksr_pkg::WD_W0: w0_reg[pcomp_reg] <= comp_val;
                    gjksr_pkg::WD_W1: w1_reg[pcomp_reg] <= comp_val;
                    default:          w2_reg[pcomp_reg] <= comp_val;
                endcase
            end
            if (pfinal_reg) begin
                pos_reg  <= !acc_c[AW-1] && (acc_c != '0);
                negf_reg <= acc_c[AW-1];
            end
        end
        if (busy_reg && op_reg == gjksr_pkg::OP_SETDIR) begin
            for (int k = 0; k < 3; k++) begin
                dir_reg[k] <= fixed[k];
            end
        end
        if (cmd.load_in) begin
            in_reg[0] <= pt_x;
            in_reg[1] <= pt_y;
            in_reg[2] <= pt_z;
        end
        unique case (cmd.perm)
            gjksr_pkg::PM_NONE: ;
            gjksr_pkg::PM_START: p_reg[0] <= in_reg;
            gjksr_pkg::PM_PUSH: begin
                p_reg[3] <= p_reg[2];
                p_reg[2] <= p_reg[1];
                p_reg[1] <= p_reg[0];
                p_reg[0] <= in_reg;
            end
            gjksr_pkg::PM_B_GETS_C: p_reg[1] <= p_reg[2];
            gjksr_pkg::PM_SWAP_BC: begin
                p_reg[1] <= p_reg[2];
                p_reg[2] <= p_reg[1];
            end
            gjksr_pkg::PM_CD: begin
                p_reg[1] <= p_reg[2];
                p_reg[2] <= p_reg[3];
            end
            gjksr_pkg::PM_DB: begin
                p_reg[1] <= p_reg[3];
                p_reg[2] <= p_reg[1];
            end
            default: ;
        endcase
        if (cmd.emit) begin
            res_status <= cmd.out_status;
            res_count  <= cmd.out_count;
            if (cmd.out_status == gjksr_pkg::STAT_CONT) begin
                res_dir_x <= dir_reg[0];
                res_dir_y <= dir_reg[1];
                res_dir_z <= dir_reg[2];
            end else begin
                res_dir_x <= '0;
                res_dir_y <= '0;
                res_dir_z <= '0;
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.pos  = pos_reg;
    assign stat.neg  = negf_reg;

endmodule

// ----- rtl/gjksr_ctrl.sv -----
module gjksr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                action,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    output gjksr_pkg::dp_cmd_t  cmd,
    input  gjksr_pkg::dp_stat_t stat
);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_ST_LD   = 22'h000002,
        S_ST_DIR  = 22'h000004,
        S_SEP_DOT = 22'h000008,
        S_PUSH    = 22'h000010,
        S_LN_DOT  = 22'h000020,
        S_LN_X1   = 22'h000040,
        S_LN_X2   = 22'h000080,
        S_TR_N    = 22'h000100,
        S_TR_X1   = 22'h000200,
        S_TR_D1   = 22'h000400,
        S_TR_D2   = 22'h000800,
        S_TR_X2   = 22'h001000,
        S_TR_D3   = 22'h002000,
        S_TR_D4   = 22'h004000,
        S_TR_D5   = 22'h008000,
        S_TT_F    = 22'h010000,
        S_TT_FL   = 22'h020000,
        S_TT_D    = 22'h040000,
        S_FIN     = 22'h080000,
        S_FIN_DIR = 22'h100000,
        S_EMIT    = 22'h200000
    } state_t;

    state_t               state_reg, state_next;
    logic                 issued_reg, issued_next;
    logic [2:0]           count_reg, count_next;
    logic [7:0]           steps_reg, steps_next;
    logic [7:0]           limit_reg, limit_next;
    logic                 active_reg, active_next;
    gjksr_pkg::status_t   status_reg, status_next;
    logic                 flip_reg, flip_next;
    logic [1:0]           face_reg, face_next;
    gjksr_pkg::wsel_t     ndsel_reg, ndsel_next;
    logic                 ndneg_reg, ndneg_next;
    logic                 ov_reg, ov_next;
    logic                 compute;
    logic                 hit;
    logic [2:0]           cn;

    assign cn = ((count_reg > 3'd3) ? 3'd3 : count_reg) + 3'd1;
    assign hit = flip_reg ? stat.neg : stat.pos;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;

    always_comb begin
        state_next  = state_reg;
        issued_next = issued_reg;
        count_next  = count_reg;
        steps_next  = steps_reg;
        limit_next  = limit_reg;
        active_next = active_reg;
        status_next = status_reg;
        flip_next   = flip_reg;
        face_next   = face_reg;
        ndsel_next  = ndsel_reg;
        ndneg_next  = ndneg_reg;
        ov_next     = ov_reg;
        compute     = 1'b0;
        cmd         = '0;
        cmd.out_status = status_reg;
        cmd.out_count  = count_reg;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        if (cfg_we) begin
            limit_next = cfg_wdata;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (!action) begin
                        state_next = S_ST_LD;
                    end else if (!active_reg) begin
                        status_next = gjksr_pkg::STAT_IDLE;
                        state_next  = S_EMIT;
                    end else begin
                        steps_next = steps_reg + 8'd1;
                        state_next = S_SEP_DOT;
                    end
                end
            end
            S_ST_LD: begin
                cmd.perm    = gjksr_pkg::PM_START;
                count_next  = 3'd1;
                steps_next  = 8'd0;
                active_next = 1'b1;
                state_next  = S_ST_DIR;
            end
            S_ST_DIR: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_SETDIR;
                cmd.wsel = gjksr_pkg::WS_AO;
                if (stat.done) begin
                    status_next = gjksr_pkg::STAT_CONT;
                    state_next  = S_EMIT;
                end
            end
            S_SEP_DOT: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_IN;
                cmd.wsel = gjksr_pkg::WS_DIR;
                if (stat.done) begin
                    if (stat.neg) begin
                        status_next = gjksr_pkg::STAT_SEP;
                        active_next = 1'b0;
                        state_next  = S_EMIT;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                cmd.perm   = gjksr_pkg::PM_PUSH;
                count_next = cn;
                face_next  = 2'd0;
                if (cn == 3'd2) begin
                    state_next = S_LN_DOT;
                end else if (cn == 3'd3) begin
                    state_next = S_TR_N;
                end else begin
                    state_next = S_TT_F;
                end
            end
            S_LN_DOT: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_AO;
                if (stat.done) begin
                    if (stat.pos) begin
                        state_next = S_LN_X1;
                    end else begin
                        count_next = 3'd1;
                        ndsel_next = gjksr_pkg::WS_AO;
                        ndneg_next = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_LN_X1: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_CROSS;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_AO;
                cmd.dst  = gjksr_pkg::WD_W0;
                if (stat.done) begin
                    state_next = S_LN_X2;
                end
            end
            S_LN_X2: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_CROSS;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_W0;
                cmd.dst  = gjksr_pkg::WD_W1;
                cmd.neg  = 1'b1;
                if (stat.done) begin
                    ndsel_next = gjksr_pkg::WS_W1;
                    ndneg_next = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_TR_N: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_CROSS;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_AC;
                cmd.dst  = gjksr_pkg::WD_W2;
                if (stat.done) begin
                    state_next = S_TR_X1;
                end
            end
            S_TR_X1: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_CROSS;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_W2;
                cmd.dst  = gjksr_pkg::WD_W0;
                if (stat.done) begin
                    state_next = S_TR_D1;
                end
            end
            S_TR_D1: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AO;
                cmd.wsel = gjksr_pkg::WS_W0;
                if (stat.done) begin
                    state_next = stat.pos ? S_TR_D2 : S_TR_X2;
                end
            end
            S_TR_D2: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AB;
                cmd.wsel = gjksr_pkg::WS_AO;
                if (stat.done) begin
                    if (stat.pos) begin
                        count_next = 3'd2;
                        state_next = S_LN_X1;
                    end else begin
                        count_next = 3'd1;
                        ndsel_next = gjksr_pkg::WS_AO;
                        ndneg_next = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_TR_X2: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_CROSS;
                cmd.ssel = gjksr_pkg::SS_AC;
                cmd.wsel = gjksr_pkg::WS_W2;
                cmd.dst  = gjksr_pkg::WD_W0;
                cmd.neg  = 1'b1;
                if (stat.done) begin
                    state_next = S_TR_D3;
                end
            end
            S_TR_D3: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AO;
                cmd.wsel = gjksr_pkg::WS_W0;
                if (stat.done) begin
                    state_next = stat.pos ? S_TR_D4 : S_TR_D5;
                end
            end
            S_TR_D4: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AC;
                cmd.wsel = gjksr_pkg::WS_AO;
                if (stat.done) begin
                    if (stat.pos) begin
                        cmd.perm   = gjksr_pkg::PM_B_GETS_C;
                        count_next = 3'd2;
                        state_next = S_LN_X1;
                    end else begin
                        count_next = 3'd1;
                        ndsel_next = gjksr_pkg::WS_AO;
                        ndneg_next = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_TR_D5: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AO;
                cmd.wsel = gjksr_pkg::WS_W2;
                if (stat.done) begin
                    ndsel_next = gjksr_pkg::WS_W2;
                    if (stat.pos) begin
                        ndneg_next = 1'b0;
                    end else begin
                        cmd.perm   = gjksr_pkg::PM_SWAP_BC;
                        ndneg_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end
            S_TT_F: begin
                compute = 1'b1;
                cmd.op  = gjksr_pkg::OP_CROSS;
                cmd.dst = gjksr_pkg::WD_W1;
                unique case (face_reg)
                    2'd0: begin cmd.ssel = gjksr_pkg::SS_AB; cmd.wsel = gjksr_pkg::WS_AC; end
                    2'd1: begin cmd.ssel = gjksr_pkg::SS_AC; cmd.wsel = gjksr_pkg::WS_AD; end
                    default: begin
                        cmd.ssel = gjksr_pkg::SS_AD;
                        cmd.wsel = gjksr_pkg::WS_AB;
                    end
                endcase
                if (stat.done) begin
                    state_next = S_TT_FL;
                end
            end
            S_TT_FL: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.wsel = gjksr_pkg::WS_W1;
                unique case (face_reg)
                    2'd0:    cmd.ssel = gjksr_pkg::SS_AD;
                    2'd1:    cmd.ssel = gjksr_pkg::SS_AB;
                    default: cmd.ssel = gjksr_pkg::SS_AC;
                endcase
                if (stat.done) begin
                    flip_next  = stat.pos;
                    state_next = S_TT_D;
                end
            end
            S_TT_D: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_DOT;
                cmd.ssel = gjksr_pkg::SS_AO;
                cmd.wsel = gjksr_pkg::WS_W1;
                if (stat.done) begin
                    if (hit) begin
                        count_next = 3'd3;
                        unique case (face_reg)
                            2'd0:    cmd.perm = gjksr_pkg::PM_NONE;
                            2'd1:    cmd.perm = gjksr_pkg::PM_CD;
                            default: cmd.perm = gjksr_pkg::PM_DB;
                        endcase
                        state_next = S_TR_N;
                    end else if (face_reg == 2'd2) begin
                        status_next = gjksr_pkg::STAT_HIT;
                        active_next = 1'b0;
                        state_next  = S_EMIT;
                    end else begin
                        face_next  = face_reg + 2'd1;
                        state_next = S_TT_F;
                    end
                end
            end
            S_FIN: begin
                if (steps_reg >= limit_reg) begin
                    status_next = gjksr_pkg::STAT_LIMIT;
                    active_next = 1'b0;
                    state_next  = S_EMIT;
                end else begin
                    state_next = S_FIN_DIR;
                end
            end
            S_FIN_DIR: begin
                compute  = 1'b1;
                cmd.op   = gjksr_pkg::OP_SETDIR;
                cmd.wsel = ndsel_reg;
                cmd.neg  = ndneg_reg;
                if (stat.done) begin
                    status_next = gjksr_pkg::STAT_CONT;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!ov_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (compute && !issued_reg) begin
            cmd.go      = 1'b1;
            issued_next = 1'b1;
        end
        if (stat.done) begin
            issued_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            count_reg  <= 3'd0;
            steps_reg  <= 8'd0;
            limit_reg  <= gjksr_pkg::LIMIT_RESET;
            active_reg <= 1'b0;
            status_reg <= gjksr_pkg::STAT_CONT;
            flip_reg   <= 1'b0;
            face_reg   <= 2'd0;
            ndsel_reg  <= gjksr_pkg::WS_AO;
            ndneg_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            count_reg  <= count_next;
            steps_reg  <= steps_next;
            limit_reg  <= limit_next;
            active_reg <= active_next;
            status_reg <= status_next;
            flip_reg   <= flip_next;
            face_reg   <= face_next;
            ndsel_reg  <= ndsel_next;
            ndneg_reg  <= ndneg_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

// ----- rtl/gjk_simplex_refiner_top.sv -----
// GJK simplex refinement core, exact integer arithmetic.
// Input stream s_*: one item per support point. s_tuser is the action
// (0 start a query, 1 add a point); s_tdata carries x, y, z.
// Result stream m_*: exactly one item per input item. m_tuser is the
// status; m_tdata carries dir_x, dir_y, dir_z and vertex_count.
// cfg_we/cfg_wdata write the iteration limit (reset value 64).
// Items are handled one at a time. The single shared signed multiplier
// runs every cross product and every dot product, one after the other,
// under the step controller.
// The result register frees the input side: the next item is taken while
// a result still waits, and the block holds before writing a new result
// while that result still waits and m_tready is low.
// Reset clears the query, the counters and the output valid; the limit
// returns to 64. No clearing pass is needed.
module gjk_simplex_refiner_top #(
    parameter int COORD_BITS = gjksr_pkg::COORD_BITS_DEF,
    localparam int IN_W = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * gjksr_pkg::DIR_BITS + 3 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // point_x, point_y, point_z
    input  logic             s_tuser,   // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // dir_x, dir_y, dir_z, vertex_count
    output logic [2:0]       m_tuser,   // status
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata
);

    localparam int CB = COORD_BITS;
    localparam int DW = gjksr_pkg::DIR_BITS;

    gjksr_pkg::dp_cmd_t  cmd;
    gjksr_pkg::dp_stat_t stat;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
    logic signed [DW-1:0] dir_z;
    logic [2:0]           vcount;

    gjksr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    gjksr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .pt_x       (s_tdata[CB-1:0]),
        .pt_y       (s_tdata[2*CB-1:CB]),
        .pt_z       (s_tdata[3*CB-1:2*CB]),
        .res_status (m_tuser),
        .res_dir_x  (dir_x),
        .res_dir_y  (dir_y),
        .res_dir_z  (dir_z),
        .res_count  (vcount)
    );

    assign m_tdata = {{(OUT_W - 3 * DW - 3){1'b0}}, vcount, dir_z, dir_y, dir_x};

endmodule

// ----- rtl/gjksr_checker.sv -----
module gjksr_checker #(
    parameter int COORD_BITS = gjksr_pkg::COORD_BITS_DEF,
    localparam int IN_W = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * gjksr_pkg::DIR_BITS + 3 + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [2:0]       m_tuser,
    input logic             cfg_we,
    input logic [7:0]       cfg_wdata
);

    localparam int DIRS = 3 * gjksr_pkg::DIR_BITS;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != gjksr_pkg::STAT_CONT) |-> (m_tdata[DIRS-1:0] == '0))
        else $error("ending status with nonzero direction");

    a_dir_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == gjksr_pkg::STAT_CONT) |-> (m_tdata[DIRS-1:0] != '0))
        else $error("continue status with zero direction");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == gjksr_pkg::STAT_HIT) |-> (m_tdata[DIRS+2:DIRS] == 3'd4))
        else $error("intersection reported without a tetrahedron");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind gjk_simplex_refiner_top gjksr_checker #(.COORD_BITS(COORD_BITS)) u_chk (.*);

// ----- test/gjk_simplex_refiner_top_tb.sv -----
module gjk_simplex_refiner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    typedef struct {
        gjksr_pkg::status_t st;
        logic [39:0] dx;
        logic [39:0] dy;
        logic [39:0] dz;
        logic [2:0]  cnt;
    } gjk_res_t;

    typedef struct {
        bit         is_cfg;
        logic [7:0] cfg_val;
        bit         act;
        int         x;
        int         y;
        int         z;
        bit         typed;
        gjksr_pkg::status_t st;
        longint     dx;
        longint     dy;
        longint     dz;
        int         cnt;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we;
    logic [7:0]   cfg_wdata;

    gjk_simplex_refiner_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // simplex model state
    vec_t        spts[4];
    int unsigned hcnt;
    vec_t        sdir;
    int unsigned steps;
    bit          active;
    int unsigned lim;

    gjk_res_t    pending_q[$];
    int          fails;
    int          cycles;
    int          burst_left;
    int          status_seen[8];
    bit          hold_req;
    bit          item_typed;
    gjk_res_t    item_exp;

    function automatic vec_t vmk(longint x, longint y, longint z);
        vec_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic vec_t vsub(vec_t a, vec_t b);
        return vmk(a.x - b.x, a.y - b.y, a.z - b.z);
    endfunction

    function automatic vec_t vneg(vec_t a);
        return vmk(-a.x, -a.y, -a.z);
    endfunction

    function automatic longint vdot(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        return vmk(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
    endfunction

    function automatic longint sat40(longint v);
        if (v > 64'sd549755813887) return 64'sd549755813887;
        if (v < -64'sd549755813888) return -64'sd549755813888;
        return v;
    endfunction

    function automatic vec_t fix_dir(vec_t d);
        vec_t r;
        r = vmk(sat40(d.x), sat40(d.y), sat40(d.z));
        if (r.x == 0 && r.y == 0 && r.z == 0) r = vmk(1, 0, 0);
        return r;
    endfunction

    function automatic vec_t line_dir();
        vec_t a, ab, ao;
        a = spts[0];
        ab = vsub(spts[1], a);
        ao = vneg(a);
        if (vdot(ab, ao) > 0) return vcross(vcross(ab, ao), ab);
        hcnt = 1;
        return ao;
    endfunction

    function automatic vec_t tri_dir();
        vec_t a, b, c, ab, ac, ao, n;
        a = spts[0];
        b = spts[1];
        c = spts[2];
        ab = vsub(b, a);
        ac = vsub(c, a);
        ao = vneg(a);
        n = vcross(ab, ac);
        if (vdot(vcross(ab, n), ao) > 0) begin
            if (vdot(ab, ao) > 0) begin
                hcnt = 2;
                return vcross(vcross(ab, ao), ab);
            end
            hcnt = 1;
            return ao;
        end
        if (vdot(vcross(n, ac), ao) > 0) begin
            if (vdot(ac, ao) > 0) begin
                hcnt = 2;
                spts[1] = c;
                return vcross(vcross(ac, ao), ac);
            end
            hcnt = 1;
            return ao;
        end
        if (vdot(n, ao) > 0) return n;
        spts[1] = c;
        spts[2] = b;
        return vneg(n);
    endfunction

    function automatic bit tet_dir(output vec_t d);
        vec_t a, b, c, dd, ab, ac, ad, ao, f1, f2, f3;
        a = spts[0];
        b = spts[1];
        c = spts[2];
        dd = spts[3];
        ab = vsub(b, a);
        ac = vsub(c, a);
        ad = vsub(dd, a);
        ao = vneg(a);
        f1 = vcross(ab, ac);
        f2 = vcross(ac, ad);
        f3 = vcross(ad, ab);
        d = vmk(0, 0, 0);
        if (vdot(f1, ad) > 0) f1 = vneg(f1);
        if (vdot(f2, ab) > 0) f2 = vneg(f2);
        if (vdot(f3, ac) > 0) f3 = vneg(f3);
        if (vdot(f1, ao) > 0) begin
            hcnt = 3;
            d = tri_dir();
            return 0;
        end
        if (vdot(f2, ao) > 0) begin
            hcnt = 3;
            spts[1] = c;
            spts[2] = dd;
            d = tri_dir();
            return 0;
        end
        if (vdot(f3, ao) > 0) begin
            hcnt = 3;
            spts[1] = dd;
            spts[2] = b;
            d = tri_dir();
            return 0;
        end
        return 1;
    endfunction

    function automatic gjk_res_t refine_step(bit act, logic [39:0] pd);
        vec_t p, nd, dout;
        gjk_res_t r;
        bit hit;
        p = vmk(longint'($signed(pd[11:0])), longint'($signed(pd[23:12])),
                longint'($signed(pd[35:24])));
        dout = vmk(0, 0, 0);
        hit = 0;
        nd = vmk(0, 0, 0);
        if (!act) begin
            spts[0] = p;
            hcnt = 1;
            steps = 0;
            active = 1;
            sdir = fix_dir(vneg(p));
            dout = sdir;
            r.st = gjksr_pkg::STAT_CONT;
        end else if (!active) begin
            r.st = gjksr_pkg::STAT_IDLE;
        end else begin
            steps = (steps + 1) & 8'hFF;
            if (vdot(p, sdir) < 0) begin
                r.st = gjksr_pkg::STAT_SEP;
                active = 0;
            end else begin
                if (hcnt > 3) hcnt = 3;
                for (int i = 3; i > 0; i--) begin
                    if (i <= hcnt) spts[i] = spts[i-1];
                end
                spts[0] = p;
                hcnt++;
                if (hcnt == 2) nd = line_dir();
                else if (hcnt == 3) nd = tri_dir();
                else hit = tet_dir(nd);
                if (hit) begin
                    r.st = gjksr_pkg::STAT_HIT;
                    active = 0;
                end else if (steps >= lim) begin
                    r.st = gjksr_pkg::STAT_LIMIT;
                    active = 0;
                end else begin
                    sdir = fix_dir(nd);
                    dout = sdir;
                    r.st = gjksr_pkg::STAT_CONT;
                end
            end
        end
        r.dx = dout.x[39:0];
        r.dy = dout.y[39:0];
        r.dz = dout.z[39:0];
        r.cnt = hcnt[2:0];
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("gjk_simplex_refiner_top test failed");
            $finish;
        end
    end

    // result check first, then prediction of the newly accepted item
    always @(posedge aclk) begin
        gjk_res_t e, p;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result item");
                fails++;
            end else begin
                e = pending_q.pop_front();
                status_seen[m_tuser]++;
                if (m_tuser !== e.st) begin
                    $error("status: expected %0d actual %0d", e.st, m_tuser);
                    fails++;
                end
                if (m_tdata[39:0] !== e.dx) begin
                    $error("dir_x: expected %0d actual %0d", $signed(e.dx),
                           $signed(m_tdata[39:0]));
                    fails++;
                end
                if (m_tdata[79:40] !== e.dy) begin
                    $error("dir_y: expected %0d actual %0d", $signed(e.dy),
                           $signed(m_tdata[79:40]));
                    fails++;
                end
                if (m_tdata[119:80] !== e.dz) begin
                    $error("dir_z: expected %0d actual %0d", $signed(e.dz),
                           $signed(m_tdata[119:80]));
                    fails++;
                end
                if (m_tdata[122:120] !== e.cnt) begin
                    $error("vertex_count: expected %0d actual %0d", e.cnt,
                           m_tdata[122:120]);
                    fails++;
                end
            end
        end
        if (aresetn && cfg_we) lim = (cfg_wdata == 0) ? 1 : cfg_wdata;
        if (aresetn && s_tvalid && s_tready) begin
            p = refine_step(s_tuser, s_tdata);
            if (item_typed) p = item_exp;
            pending_q.insert(pending_q.size(), p);
        end
    end

    initial begin
        int ready_pct;
        int span;
        m_tready = 0;
        ready_pct = 100;
        span = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 0;
                for (int i = 0; i < 400; i++) @(negedge aclk);
                hold_req = 0;
            end
            if (span == 0) begin
                span = $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 60;
                    default: ready_pct = 20;
                endcase
            end
            span--;
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic send_item(bit act, int x, int y, int z, bit typed, gjk_res_t e);
        int gap;
        logic [11:0] cx, cy, cz;
        cx = x[11:0];
        cy = y[11:0];
        cz = z[11:0];
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1;
        s_tuser <= act;
        s_tdata <= {4'b0, cz, cy, cx};
        item_typed <= typed;
        item_exp <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(logic [7:0] v);
        wait_idle();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    function automatic int neg_coord(int v);
        return (v == -2048) ? 2047 : -v;
    endfunction

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 200) - 100;
            1: return $urandom_range(0, 4095) - 2048;
            default: begin
                case ($urandom_range(0, 2))
                    0: return -2048;
                    1: return 2047;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_mode();
        int r;
        r = $urandom_range(0, 9);
        return (r < 7) ? 0 : (r < 9) ? 1 : 2;
    endfunction

    row_t dir_rows[] = '{
        '{0, 8'd0, 1, 5, 5, 5, 1, gjksr_pkg::STAT_IDLE, 0, 0, 0, 0},
        '{0, 8'd0, 0, 0, 0, 0, 1, gjksr_pkg::STAT_CONT, 1, 0, 0, 1},
        '{0, 8'd0, 1, -5, 0, 0, 1, gjksr_pkg::STAT_SEP, 0, 0, 0, 1},
        '{0, 8'd0, 1, 3, 3, 3, 1, gjksr_pkg::STAT_IDLE, 0, 0, 0, 1},
        '{0, 8'd0, 0, 2047, 2047, 2047, 1, gjksr_pkg::STAT_CONT, -2047, -2047, -2047, 1},
        '{0, 8'd0, 1, -2048, -2048, -2048, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 2047, -2048, 0, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, -2048, 2047, 2047, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 0, 0, -2048, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 0, -2048, -2048, -2048, 1, gjksr_pkg::STAT_CONT, 2048, 2048, 2048, 1},
        '{0, 8'd0, 1, 2047, 2047, -2048, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 0, 10, 0, 0, 1, gjksr_pkg::STAT_CONT, -10, 0, 0, 1},
        '{0, 8'd0, 1, -10, 1, 0, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 0, -10, 1, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 0, 0, -10, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 0, 10, 10, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 1, 1, 1, 10, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{1, 8'd1, 0, 0, 0, 0, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0},
        '{0, 8'd0, 0, 0, 0, 0, 1, gjksr_pkg::STAT_CONT, 1, 0, 0, 1},
        '{0, 8'd0, 1, 1, 0, 0, 1, gjksr_pkg::STAT_LIMIT, 0, 0, 0, 2},
        '{0, 8'd0, 1, 1, 0, 0, 1, gjksr_pkg::STAT_IDLE, 0, 0, 0, 2},
        '{1, 8'd255, 0, 0, 0, 0, 0, gjksr_pkg::STAT_CONT, 0, 0, 0, 0}
    };

    initial begin
        logic [7:0] limits[5];
        gjk_res_t e;
        int px, py, pz, mode, adds;
        vec_t pv;
        limits = '{8'd1, 8'd255, 8'd2, 8'd8, 8'd64};
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        hold_req = 0;
        item_typed = 0;
        item_exp = '{gjksr_pkg::STAT_CONT, 0, 0, 0, 0};
        fails = 0;
        cycles = 0;
        burst_left = 0;
        hcnt = 0;
        sdir = vmk(0, 0, 0);
        steps = 0;
        active = 0;
        lim = 64;
        for (int i = 0; i < 4; i++) spts[i] = vmk(0, 0, 0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_limit(dir_rows[i].cfg_val);
            end else begin
                e.st = dir_rows[i].st;
                e.dx = dir_rows[i].dx[39:0];
                e.dy = dir_rows[i].dy[39:0];
                e.dz = dir_rows[i].dz[39:0];
                e.cnt = dir_rows[i].cnt[2:0];
                send_item(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y,
                          dir_rows[i].z, dir_rows[i].typed, e);
            end
        end

        foreach (limits[ph]) begin
            int sent;
            write_limit(limits[ph]);
            sent = 0;
            if (ph == 1) hold_req = 1;
            while (sent < 360) begin
                if ($urandom_range(0, 99) < 80) begin
                    mode = pick_mode();
                    send_item(0, rand_coord(mode), rand_coord(mode), rand_coord(mode), 0, e);
                    sent++;
                    adds = $urandom_range(1, 14);
                    while (adds > 0 && active) begin
                        mode = pick_mode();
                        px = rand_coord(mode);
                        py = rand_coord(mode);
                        pz = rand_coord(mode);
                        pv = vmk(px, py, pz);
                        if (vdot(pv, sdir) < 0 && $urandom_range(0, 19) != 0) begin
                            px = neg_coord(px);
                            py = neg_coord(py);
                            pz = neg_coord(pz);
                        end
                        send_item(1, px, py, pz, 0, e);
                        sent++;
                        adds--;
                    end
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_item($urandom_range(0, 2) != 0, rand_coord(1), rand_coord(1),
                                  rand_coord(1), 0, e);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        $display("covered: limits 1, 2, 8, 64, 255; random queries with bursty input");
        $display("results: %0d continue, %0d hit, %0d separated, %0d limit, %0d idle",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fails == 0) begin
            $display("gjk_simplex_refiner_top test passed");
        end else begin
            $display("gjk_simplex_refiner_top test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/gjksr_pkg.sv
rtl/gjksr_dp.sv
rtl/gjksr_ctrl.sv
rtl/gjk_simplex_refiner_top.sv
rtl/gjksr_checker.sv
test/gjk_simplex_refiner_top_tb.sv
